FILE: hw/rtl/m4vt_pkg.sv
// m4vt_pkg: shared widths, types and codes for the 4x4 matrix-vector transform
// no dependencies; imported by every module of the block

package m4vt_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int LANES         = 4;
    localparam int COEFS         = LANES * LANES;
    localparam int COEF_IDX_W    = 4;
    localparam int DATA_W        = 32;
    localparam int PROD_W        = 2 * DATA_W;
    // four full products summed without loss
    localparam int SUM_W         = PROD_W + 2;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic [COEF_IDX_W-1:0]    coef_idx_t;

    typedef enum logic
    {
        FUNC_LOAD  = 1'b0,
        FUNC_XFORM = 1'b1
    } func_t;

    // pipeline control handed to the merge stage
    typedef struct packed
    {
        logic adv;
        logic vld;
    } ctl_t;

    localparam data_t SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam data_t SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

FILE: hw/rtl/m4vt_lane.sv
// m4vt_lane: one output row, four registered products then a registered sum
// depends on m4vt_pkg

module m4vt_lane
(
    input  logic             clk,
    input  logic             en,
    input  m4vt_pkg::data_t  coef [m4vt_pkg::LANES],
    input  m4vt_pkg::data_t  vec  [m4vt_pkg::LANES],
    output m4vt_pkg::sum_t   sum
);
    import m4vt_pkg::*;

    prod_t prod_reg [LANES];
    sum_t  sum_reg;
    sum_t  sum_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < LANES; c++)
            begin
                prod_reg[c] <= PROD_W'(coef[c] * vec[c]);
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int c = 0; c < LANES; c++)
        begin
            sum_next = sum_next + SUM_W'(prod_reg[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

FILE: hw/rtl/m4vt_merge.sv
// m4vt_merge: shifts and saturates the lane sums, merges the clip flags and
// holds the result word; depends on m4vt_pkg

module m4vt_merge #(
    parameter int FRAC_BITS = m4vt_pkg::FRAC_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  m4vt_pkg::ctl_t   ctl,
    input  m4vt_pkg::sum_t   sum [m4vt_pkg::LANES],
    output m4vt_pkg::data_t  res [m4vt_pkg::LANES],
    output logic             sat,
    output logic             vld
);
    import m4vt_pkg::*;

    localparam int SH_W = SUM_W - FRAC_BITS;

    logic signed [SH_W-1:0] sh [LANES];
    data_t                  res_next [LANES];
    logic [LANES-1:0]       clip;
    data_t                  res_reg [LANES];
    logic                   sat_reg;
    logic                   vld_reg;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            sh[l] = SH_W'(sum[l] >>> FRAC_BITS);
            // fits when every bit above the sign position agrees
            if ((&sh[l][SH_W-1:DATA_W-1]) || !(|sh[l][SH_W-1:DATA_W-1]))
            begin
                clip[l]     = 1'b0;
                res_next[l] = sh[l][DATA_W-1:0];
            end
            else
            begin
                clip[l]     = 1'b1;
                res_next[l] = sh[l][SH_W-1] ? SAT_MIN : SAT_MAX;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (ctl.adv)
        begin
            vld_reg <= ctl.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            res_reg <= res_next;
            sat_reg <= |clip;
        end
    end

    assign res = res_reg;
    assign sat = sat_reg;
    assign vld = vld_reg;

endmodule

FILE: hw/rtl/mat4_vector_transform.sv
// mat4_vector_transform: 4x4 column-major matrix times vector, signed fixed point
// a transform word passes the product, sum and output registers before it shows on rsp_valid
// throughput: one word per cycle; the three pipeline stages move together and
// stall only while a finished result word waits for rsp_ready
// reset: coefficients go to identity, pipeline and output register empty
// depends on m4vt_pkg, m4vt_lane, m4vt_merge

module mat4_vector_transform #(
    parameter int FRAC_BITS = m4vt_pkg::FRAC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic                func,
    input  m4vt_pkg::coef_idx_t coef_index,
    input  m4vt_pkg::data_t     coef_value,
    input  m4vt_pkg::data_t     vec_x,
    input  m4vt_pkg::data_t     vec_y,
    input  m4vt_pkg::data_t     vec_z,
    input  m4vt_pkg::data_t     vec_w,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output m4vt_pkg::data_t     out_x,
    output m4vt_pkg::data_t     out_y,
    output m4vt_pkg::data_t     out_z,
    output m4vt_pkg::data_t     out_w,
    output logic                saturated
);
    import m4vt_pkg::*;

    // 1.0 in the chosen fixed-point format
    localparam data_t ONE = data_t'(1) << FRAC_BITS;

    data_t coef_reg [COEFS];
    data_t vec      [LANES];
    sum_t  sum      [LANES];
    data_t res      [LANES];

    logic  adv;
    logic  accept;
    logic  load;
    logic  xform;
    logic  v1_reg;
    logic  v2_reg;
    ctl_t  merge_ctl;

    // whole pipeline advances unless the output word is held
    assign adv       = !rsp_valid || rsp_ready;
    assign req_ready = adv;
    assign accept    = req_valid && req_ready;
    assign load      = accept && (func == FUNC_LOAD);
    assign xform     = accept && (func == FUNC_XFORM);

    assign vec[0] = vec_x;
    assign vec[1] = vec_y;
    assign vec[2] = vec_z;
    assign vec[3] = vec_w;

    // coefficient bank, written straight from the load word so that a
    // transform right behind it already sees the new value
    for (genvar gi = 0; gi < COEFS; gi++)
    begin : g_coef
        localparam data_t RST_VAL = ((gi / LANES) == (gi % LANES)) ? ONE : '0;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                coef_reg[gi] <= RST_VAL;
            end
            else if (load && (coef_index == COEF_IDX_W'(gi)))
            begin
                coef_reg[gi] <= coef_value;
            end
        end
    end

    // one lane per output row; row r uses coefficient c*4+r of each column
    for (genvar gr = 0; gr < LANES; gr++)
    begin : g_lane
        data_t row_coef [LANES];

        for (genvar gc = 0; gc < LANES; gc++)
        begin : g_col
            assign row_coef[gc] = coef_reg[gc * LANES + gr];
        end

        m4vt_lane u_lane
        (
            .clk  (clk),
            .en   (adv),
            .coef (row_coef),
            .vec  (vec),
            .sum  (sum[gr])
        );
    end

    // valid marks for the product and sum stages; load words leave a bubble
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= xform;
            v2_reg <= v1_reg;
        end
    end

    assign merge_ctl.adv = adv;
    assign merge_ctl.vld = v2_reg;

    m4vt_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (merge_ctl),
        .sum   (sum),
        .res   (res),
        .sat   (saturated),
        .vld   (rsp_valid)
    );

    assign out_x = res[0];
    assign out_y = res[1];
    assign out_z = res[2];
    assign out_w = res[3];

    // a load lands in the addressed coefficient register
    a_load_lands: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> coef_reg[$past(coef_index)] == $past(coef_value))
        else $error("coefficient load lost");

    // an accepted transform enters the product stage
    a_xform_enters: assert property (@(posedge clk) disable iff (!rst_n)
        xform |=> v1_reg)
        else $error("transform word dropped");

    // a held output freezes the internal stages
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v1_reg) && $stable(v2_reg))
        else $error("pipeline moved during stall");

    // a clip flag means some component sits at a rail
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && saturated) |->
            (out_x == SAT_MAX) || (out_x == SAT_MIN) ||
            (out_y == SAT_MAX) || (out_y == SAT_MIN) ||
            (out_z == SAT_MAX) || (out_z == SAT_MIN) ||
            (out_w == SAT_MAX) || (out_w == SAT_MIN))
        else $error("saturated flag without clipped component");

endmodule
